FILE: hw/rtl/iprf_pkg.sv
`timescale 1ns / 1ps

package iprf_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned IdW       = 16;
  localparam int unsigned SeqW      = 16;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PROBE_ID = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ATTEMPTS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HOP_TTL  = 2'd2;

  // icmp types
  localparam logic [ByteW-1:0] ICMP_ECHO_REPLY   = 8'd0;
  localparam logic [ByteW-1:0] ICMP_TIME_EXCEEDED = 8'd11;

  // reply kind codes
  localparam logic [1:0] KIND_ECHO_REPLY   = 2'd0;
  localparam logic [1:0] KIND_TIME_EXCEEDED = 2'd1;
  localparam logic [1:0] KIND_OTHER        = 2'd2;
  localparam logic [1:0] KIND_TRUNCATED    = 2'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic byte_en;      // take the current byte into the packet state
    logic load_result;  // write the verdict to the output register, clear packet state
  } iprf_cmd_t;

  typedef enum logic [1:0] {
    S_RECV = 2'b01,
    S_EVAL = 2'b10
  } iprf_state_e;

endpackage

FILE: hw/rtl/icmp_probe_reply_filter.sv
`timescale 1ns / 1ps

// Matches received IPv4 packets against outstanding echo probes. Packet bytes are
// taken one per cycle while receiving; after the byte marked last the block forms
// the verdict in the evaluation stage and takes no bytes until the verdict is
// loaded. The verdict sits in an output register, so the next packet may start
// while it waits to be taken; a second verdict waits in evaluation until the
// register frees up. The sequence window is registered from the attempts and
// hop TTL registers; write configuration only between packets.
module icmp_probe_reply_filter
  import iprf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ByteW-1:0]    data_byte_i,
  input  logic                last_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                accepted_o,
  output logic [1:0]          reply_kind_o,
  output logic [AddrW-1:0]    source_address_o
);

  iprf_cmd_t cmd;

  iprf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_byte_i (last_byte_i),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  iprf_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .accepted_o       (accepted_o),
    .reply_kind_o     (reply_kind_o),
    .source_address_o (source_address_o)
  );

endmodule

FILE: hw/rtl/iprf_ctrl.sv
`timescale 1ns / 1ps

module iprf_ctrl
  import iprf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      last_byte_i,
  input  logic      out_ready_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  output iprf_cmd_t cmd_o
);

  iprf_state_e state_q, state_d;
  logic        ovalid_q, ovalid_d;
  logic        take_byte;
  logic        load;

  assign in_ready_o  = (state_q == S_RECV);
  assign out_valid_o = ovalid_q;
  assign take_byte   = in_valid_i & in_ready_o;
  // verdict goes out once the output register is free or being emptied
  assign load        = (state_q == S_EVAL) & (~ovalid_q | out_ready_i);

  assign cmd_o.byte_en     = take_byte;
  assign cmd_o.load_result = load;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_RECV: begin
        if (take_byte && last_byte_i) state_d = S_EVAL;
      end
      S_EVAL: begin
        if (load) state_d = S_RECV;
      end
      default: state_d = S_RECV;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (load) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_RECV;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_byte && last_byte_i) |=> (state_q == S_EVAL))
    else $error("final byte did not start evaluation");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!ovalid_q || out_ready_i))
    else $error("verdict overwrote a pending result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (ovalid_q && state_q == S_RECV))
    else $error("loaded verdict not presented");
`endif

endmodule

FILE: hw/rtl/iprf_datapath.sv
`timescale 1ns / 1ps

module iprf_datapath
  import iprf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  iprf_cmd_t           cmd_i,
  input  logic [ByteW-1:0]    data_byte_i,
  input  logic                last_byte_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                accepted_o,
  output logic [1:0]          reply_kind_o,
  output logic [AddrW-1:0]    source_address_o
);

  // start of the echo id/sequence for a given header layout
  function automatic logic [ByteW-1:0] echo_base(logic [3:0] ohl, logic [3:0] ihl,
                                                 logic [ByteW-1:0] kind);
    logic [ByteW-1:0] hdr_off;
    hdr_off = {2'b00, ohl, 2'b00};
    if (kind == ICMP_ECHO_REPLY) begin
      return hdr_off + 8'd4;
    end
    return hdr_off + 8'd12 + {2'b00, ihl, 2'b00};
  endfunction

  // configuration
  logic [IdW-1:0]   probe_id_q;
  logic [ByteW-1:0] attempts_q;
  logic [ByteW-1:0] hop_ttl_q;
  logic [SeqW-1:0]  seq_lo_q;
  logic [SeqW:0]    seq_hi_q;

  // packet state
  logic [ByteW-1:0] offset_q, offset_d;
  logic [3:0]       ohl_q, ohl_d;
  logic [3:0]       ihl_q, ihl_d;
  logic [ByteW-1:0] kind_q, kind_d;
  logic [IdW-1:0]   id_q, id_d;
  logic [SeqW-1:0]  seq_q, seq_d;
  logic [AddrW-1:0] src_q, src_d;

  // output register
  logic             acc_q;
  logic [1:0]       rkind_q;
  logic [AddrW-1:0] rsrc_q;

  logic [ByteW-1:0] idx;
  logic [ByteW-1:0] off;
  logic [ByteW-1:0] base;
  logic             has_base;

  logic [ByteW-1:0] e_off;
  logic [ByteW-1:0] e_base;
  logic             e_has_base;
  logic             e_trunc;
  logic             e_match;
  logic             v_acc;
  logic [1:0]       v_kind;
  logic [AddrW-1:0] v_src;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_id_q <= '0;
      attempts_q <= 8'd3;
      hop_ttl_q  <= 8'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PROBE_ID: probe_id_q <= cfg_data_i;
        CFG_ATTEMPTS: attempts_q <= cfg_data_i[ByteW-1:0];
        CFG_HOP_TTL:  hop_ttl_q  <= cfg_data_i[ByteW-1:0];
        default: ;
      endcase
    end
  end

  // sequence window [ttl*attempts, (ttl+1)*attempts), taken from the config registers
  always_ff @(posedge clk_i) begin
    seq_lo_q <= 16'(hop_ttl_q) * 16'(attempts_q);
    seq_hi_q <= 17'({1'b0, hop_ttl_q} + 9'd1) * 17'(attempts_q);
  end

  // byte capture
  always_comb begin
    idx      = offset_q;
    offset_d = offset_q;
    ohl_d    = ohl_q;
    ihl_d    = ihl_q;
    kind_d   = kind_q;
    id_d     = id_q;
    seq_d    = seq_q;
    src_d    = src_q;

    if (idx == 8'd0) ohl_d = data_byte_i[3:0];
    off = {2'b00, ohl_d, 2'b00};

    if (idx >= 8'd12 && idx <= 8'd15) begin
      case (idx[1:0])
        2'd0:    src_d[31:24] = data_byte_i;
        2'd1:    src_d[23:16] = data_byte_i;
        2'd2:    src_d[15:8]  = data_byte_i;
        default: src_d[7:0]   = data_byte_i;
      endcase
    end
    if (idx == off) kind_d = data_byte_i;
    if (idx == off + 8'd8) ihl_d = data_byte_i[3:0];

    has_base = (kind_d == ICMP_ECHO_REPLY) || (kind_d == ICMP_TIME_EXCEEDED);
    base     = echo_base(ohl_d, ihl_d, kind_d);
    if (has_base) begin
      if (idx == base) begin
        id_d[7:0] = data_byte_i;
      end else if (idx == base + 8'd1) begin
        id_d[15:8] = data_byte_i;
      end else if (idx == base + 8'd2) begin
        seq_d[7:0] = data_byte_i;
      end else if (idx == base + 8'd3) begin
        seq_d[15:8] = data_byte_i;
      end
    end

    // offset holds the final byte's position for evaluation
    if (!last_byte_i && offset_q != 8'hff) offset_d = offset_q + 8'd1;
  end

  // verdict from the settled packet state
  always_comb begin
    e_off      = {2'b00, ohl_q, 2'b00};
    e_has_base = (kind_q == ICMP_ECHO_REPLY) || (kind_q == ICMP_TIME_EXCEEDED);
    e_base     = echo_base(ohl_q, ihl_q, kind_q);
    e_trunc    = (offset_q < e_off) || (offset_q < 8'd15)
              || ((kind_q == ICMP_TIME_EXCEEDED) && (offset_q < e_off + 8'd8))
              || (e_has_base && (offset_q < e_base + 8'd3));
    e_match    = (id_q == probe_id_q) && (seq_q >= seq_lo_q)
              && ({1'b0, seq_q} < seq_hi_q);

    v_src = src_q;
    if (e_trunc) begin
      v_acc  = 1'b0;
      v_kind = KIND_TRUNCATED;
      v_src  = '0;
    end else if (kind_q == ICMP_ECHO_REPLY) begin
      v_acc  = e_match;
      v_kind = KIND_ECHO_REPLY;
    end else if (kind_q == ICMP_TIME_EXCEEDED) begin
      v_acc  = e_match;
      v_kind = KIND_TIME_EXCEEDED;
    end else begin
      v_acc  = 1'b1;
      v_kind = KIND_OTHER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      ohl_q    <= '0;
      ihl_q    <= '0;
      kind_q   <= '0;
      id_q     <= '0;
      seq_q    <= '0;
      src_q    <= '0;
    end else if (cmd_i.load_result) begin
      offset_q <= '0;
      ohl_q    <= '0;
      ihl_q    <= '0;
      kind_q   <= '0;
      id_q     <= '0;
      seq_q    <= '0;
      src_q    <= '0;
    end else if (cmd_i.byte_en) begin
      offset_q <= offset_d;
      ohl_q    <= ohl_d;
      ihl_q    <= ihl_d;
      kind_q   <= kind_d;
      id_q     <= id_d;
      seq_q    <= seq_d;
      src_q    <= src_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      acc_q   <= v_acc;
      rkind_q <= v_kind;
      rsrc_q  <= v_src;
    end
  end

  assign accepted_o       = acc_q;
  assign reply_kind_o     = rkind_q;
  assign source_address_o = rsrc_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_result |=> (offset_q == '0 && kind_q == '0 && src_q == '0))
    else $error("packet state not cleared after verdict");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_result |=> ((rkind_q != KIND_TRUNCATED) || (!acc_q && rsrc_q == '0)))
    else $error("truncated verdict carries data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.byte_en && cmd_i.load_result))
    else $error("byte taken during evaluation");
`endif

endmodule
